// File: rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int DEF_DIGIT_BUFFER = 32;
    localparam int DEF_MAX_OUTPUT   = 64;

    localparam int VALUE_W = 64;
    localparam int CHUNK_W = 8;
    localparam int CHUNKS  = VALUE_W / CHUNK_W;
    // wide enough for field width plus sign or prefix
    localparam int CNT_W   = 9;

    localparam logic [2:0] CONV_SDEC = 3'd0;
    localparam logic [2:0] CONV_OCT  = 3'd1;
    localparam logic [2:0] CONV_UDEC = 3'd2;
    localparam logic [2:0] CONV_HEXL = 3'd3;
    localparam logic [2:0] CONV_HEXU = 3'd4;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef enum logic [1:0] {
        BASE_8,
        BASE_10,
        BASE_16
    } t_base;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIG_CHECK,
        ST_DIG_WAIT,
        ST_PLAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               load;
        logic               start;
        t_base              base;
        logic [VALUE_W-1:0] value;
    } t_div_ctl;

    typedef struct packed {
        logic       done;
        logic       zero;
        logic [3:0] digit;
    } t_div_stat;

    typedef struct packed {
        logic [2:0] conversion;
        logic       left_justify;
        logic       plus_sign;
        logic       space_sign;
        logic       zero_pad;
        logic       alternate_form;
        logic [6:0] field_width;
        logic       precision_given;
        logic [5:0] precision;
        logic       negative;
    } t_spec;

endpackage

`default_nettype wire

// File: rtl/core/itoa_div_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit extractor: one remainder per start command.
// Base 8/16 take a single shift; base 10 runs a restoring divide, one byte per cycle.
module itoa_div_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire itoa_pkg::t_div_ctl  i_ctl,
    output itoa_pkg::t_div_stat      o_stat
);
    import itoa_pkg::*;

    localparam int STEP_W = $clog2(CHUNKS);

    logic [VALUE_W-1:0] r_work;
    logic [3:0]         r_rem;
    logic [3:0]         r_digit;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;

    logic [3:0]         n_rem;
    logic [CHUNK_W-1:0] n_quot;

    // one byte of long division by ten, most significant bit first
    always_comb begin : div_chunk
        logic [4:0] acc;
        logic [3:0] rem;
        rem    = r_rem;
        n_quot = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            acc = {rem, r_work[VALUE_W - CHUNK_W + i]};
            if (acc >= {1'b0, DEC_BASE}) begin
                acc       = acc - {1'b0, DEC_BASE};
                n_quot[i] = 1'b1;
            end
            rem = acc[3:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
            r_step <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.load) begin
                r_work <= i_ctl.value;
            end else if (r_busy) begin
                // quotient bits enter at the bottom as dividend bytes leave the top
                r_work <= {r_work[VALUE_W-CHUNK_W-1:0], n_quot};
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(CHUNKS - 1)) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_digit <= n_rem;
                end
            end else if (i_ctl.start) begin
                case (i_ctl.base)
                    BASE_8: begin
                        r_digit <= {1'b0, r_work[2:0]};
                        r_work  <= r_work >> 3;
                        r_done  <= 1'b1;
                    end
                    BASE_16: begin
                        r_digit <= r_work[3:0];
                        r_work  <= r_work >> 4;
                        r_done  <= 1'b1;
                    end
                    default: begin
                        r_busy <= 1'b1;
                        r_rem  <= '0;
                        r_step <= '0;
                    end
                endcase
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.zero  = (r_work == '0);
    assign o_stat.digit = r_digit;

endmodule

`default_nettype wire

// File: rtl/core/itoa_emit.sv
`timescale 1ns / 1ps
`default_nettype none

// Field layout, digit store and character output pipeline.
module itoa_emit #(
    parameter int DIGIT_BUFFER = itoa_pkg::DEF_DIGIT_BUFFER,
    parameter int MAX_OUTPUT   = itoa_pkg::DEF_MAX_OUTPUT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_plan,
    input  wire itoa_pkg::t_spec                   i_spec,
    input  wire logic [$clog2(DIGIT_BUFFER+1)-1:0] i_nd,
    input  wire logic                              i_dig_we,
    input  wire logic [$clog2(DIGIT_BUFFER)-1:0]   i_dig_addr,
    input  wire logic [3:0]                        i_dig_data,
    output logic                                   o_busy,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [7:0]                             o_character,
    output logic                                   o_last,
    output logic                                   o_empty_res
);
    import itoa_pkg::*;

    localparam int AW = $clog2(DIGIT_BUFFER);
    localparam int PW = $clog2(MAX_OUTPUT + 1);

    // layout boundaries: lead spaces | prefix | zeros | digits | trail spaces
    logic [CNT_W-1:0] r_b1, r_b2, r_b3, r_b4, r_end;
    logic [7:0]       r_pre0, r_pre1;
    logic             r_upper;
    logic [CNT_W-1:0] n_b1, n_b2, n_b3, n_b4, n_end;
    logic [7:0]       n_pre0, n_pre1;

    logic [3:0]       r_store [DIGIT_BUFFER];
    logic [3:0]       r_dig_q;

    logic             r_gen;
    logic [PW-1:0]    r_pos;

    logic             r_s1_valid;
    logic [7:0]       r_s1_char;
    logic             r_s1_digit;
    logic             r_s1_upper;
    logic             r_s1_last;
    logic             r_s1_empty;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             r_out_empty;

    logic [CNT_W-1:0] pos_ext, pos_next, dig_off;
    logic             s1_load, s2_load;
    logic [7:0]       g_char;
    logic             g_digit, g_last, g_empty;
    logic [7:0]       s1_char;

    always_comb begin : plan
        logic [CNT_W-1:0] nd, wid, minp, prec, plen, total, pad;
        nd     = CNT_W'(i_nd);
        wid    = CNT_W'(i_spec.field_width);
        minp   = i_spec.precision_given ? CNT_W'(i_spec.precision) : CNT_W'(1);
        plen   = '0;
        n_pre0 = CH_NUL;
        n_pre1 = CH_NUL;
        // octal alternate form forces one leading zero digit
        if (i_spec.conversion == CONV_OCT && i_spec.alternate_form && minp <= nd) begin
            minp = nd + CNT_W'(1);
        end
        prec = (nd > minp) ? nd : minp;
        if (i_spec.conversion == CONV_SDEC) begin
            if (i_spec.negative) begin
                plen   = CNT_W'(1);
                n_pre0 = CH_MINUS;
            end else if (i_spec.plus_sign) begin
                plen   = CNT_W'(1);
                n_pre0 = CH_PLUS;
            end else if (i_spec.space_sign) begin
                plen   = CNT_W'(1);
                n_pre0 = CH_SPACE;
            end
        end else if ((i_spec.conversion == CONV_HEXL || i_spec.conversion == CONV_HEXU)
                     && i_spec.alternate_form && nd != '0) begin
            plen   = CNT_W'(2);
            n_pre0 = CH_ZERO;
            n_pre1 = (i_spec.conversion == CONV_HEXU) ? CH_UPPER_X : CH_LOWER_X;
        end
        if (i_spec.zero_pad && !i_spec.precision_given && !i_spec.left_justify
            && wid > prec + plen) begin
            prec = wid - plen;
        end
        total = prec + plen;
        pad   = (wid > total) ? (wid - total) : '0;
        n_b1  = i_spec.left_justify ? '0 : pad;
        n_b2  = n_b1 + plen;
        n_b3  = n_b2 + (prec - nd);
        n_b4  = n_b1 + total;
        n_end = pad + total;
        // unknown conversion: nothing printed
        if (i_spec.conversion > CONV_HEXU) begin
            n_b1 = '0;
            n_b2 = '0;
            n_b3 = '0;
            n_b4 = '0;
            n_end = '0;
        end
    end

    assign pos_ext  = CNT_W'(r_pos);
    assign pos_next = pos_ext + CNT_W'(1);
    // digits leave most significant first: index b4 - 1 - pos
    assign dig_off  = r_b4 - pos_next;

    assign s2_load = r_s1_valid && (!r_out_valid || !i_stall);
    assign s1_load = r_gen && (!r_s1_valid || s2_load);

    always_comb begin
        g_char  = CH_SPACE;
        g_digit = 1'b0;
        g_empty = 1'b0;
        g_last  = (pos_next == r_end) || (pos_next == CNT_W'(MAX_OUTPUT));
        if (r_end == '0) begin
            g_char  = CH_NUL;
            g_empty = 1'b1;
            g_last  = 1'b1;
        end else if (pos_ext < r_b1) begin
            g_char = CH_SPACE;
        end else if (pos_ext < r_b2) begin
            g_char = (pos_ext == r_b1) ? r_pre0 : r_pre1;
        end else if (pos_ext < r_b3) begin
            g_char = CH_ZERO;
        end else if (pos_ext < r_b4) begin
            g_digit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dig_we) begin
            r_store[i_dig_addr] <= i_dig_data;
        end
        if (s1_load) begin
            r_dig_q <= r_store[dig_off[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= 1'b0;
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_plan) begin
                r_gen <= 1'b1;
                r_pos <= '0;
            end else if (s1_load) begin
                r_pos <= r_pos + PW'(1);
                if (g_last) begin
                    r_gen <= 1'b0;
                end
            end
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_plan) begin
            r_b1    <= n_b1;
            r_b2    <= n_b2;
            r_b3    <= n_b3;
            r_b4    <= n_b4;
            r_end   <= n_end;
            r_pre0  <= n_pre0;
            r_pre1  <= n_pre1;
            r_upper <= (i_spec.conversion == CONV_HEXU);
        end
        if (s1_load) begin
            r_s1_char  <= g_char;
            r_s1_digit <= g_digit;
            r_s1_upper <= r_upper;
            r_s1_last  <= g_last;
            r_s1_empty <= g_empty;
        end
        if (s2_load) begin
            r_out_char  <= s1_char;
            r_out_last  <= r_s1_last;
            r_out_empty <= r_s1_empty;
        end
    end

    always_comb begin
        s1_char = r_s1_char;
        if (r_s1_digit) begin
            if (r_dig_q < DEC_BASE) begin
                s1_char = CH_ZERO + {4'b0, r_dig_q};
            end else begin
                s1_char = (r_s1_upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0, r_dig_q}
                          - {4'b0, DEC_BASE};
            end
        end
    end

    assign o_busy      = r_gen;
    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

endmodule

`default_nettype wire

// File: rtl/core/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// input     in         i_valid/o_stall   i_value, i_conversion, i_size_code, flags,
//                                        i_field_width, i_precision_given, i_precision
// output    out        o_valid/i_stall   o_character, o_last, o_empty_res
//
// Digits are extracted one at a time in the single divide unit: a base-10 digit takes eight
// byte steps of long division, base 8/16 a single shift. Characters then leave at one
// character per cycle while the output is not stalled.
// Reset: synchronous, active low; clears the sequencer and the output valid flags and
// holds the input stalled while asserted.
// An item is taken only in idle; the last character may still wait in the output stage.
// A stalled output holds its character; the character pipeline then stops in place.
module integer_to_ascii_formatter #(
    parameter int DIGIT_BUFFER = itoa_pkg::DEF_DIGIT_BUFFER,
    parameter int MAX_OUTPUT   = itoa_pkg::DEF_MAX_OUTPUT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_value,
    input  wire logic [2:0]  i_conversion,
    input  wire logic [1:0]  i_size_code,
    input  wire logic        i_left_justify,
    input  wire logic        i_plus_sign,
    input  wire logic        i_space_sign,
    input  wire logic        i_zero_pad,
    input  wire logic        i_alternate_form,
    input  wire logic [6:0]  i_field_width,
    input  wire logic        i_precision_given,
    input  wire logic [5:0]  i_precision,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_character,
    output logic             o_last,
    output logic             o_empty_res
);
    import itoa_pkg::*;

    localparam int ND_W = $clog2(DIGIT_BUFFER + 1);
    localparam int AW   = $clog2(DIGIT_BUFFER);

    t_state             r_state, n_state;
    t_spec              r_spec;
    logic [ND_W-1:0]    r_nd;

    logic               accept;
    logic [VALUE_W-1:0] masked, mask, load_value;
    logic               sign_bit, negative;
    logic               full;
    logic               plan;
    logic               dig_we;
    logic               div_start;
    logic               emit_busy;
    t_base              base;
    t_div_ctl           div_ctl;
    t_div_stat          div_stat;

    assign accept = i_valid && !o_stall;

    // cut the argument to its size, then take magnitude for signed decimal
    always_comb begin
        case (i_size_code)
            SIZE_8: begin
                mask     = VALUE_W'(64'h0000_0000_0000_00FF);
                sign_bit = i_value[7];
            end
            SIZE_16: begin
                mask     = VALUE_W'(64'h0000_0000_0000_FFFF);
                sign_bit = i_value[15];
            end
            SIZE_32: begin
                mask     = VALUE_W'(64'h0000_0000_FFFF_FFFF);
                sign_bit = i_value[31];
            end
            default: begin
                mask     = '1;
                sign_bit = i_value[63];
            end
        endcase
        masked     = i_value & mask;
        negative   = (i_conversion == CONV_SDEC) && sign_bit;
        load_value = negative ? ((~masked + VALUE_W'(1)) & mask) : masked;
    end

    always_comb begin
        case (r_spec.conversion)
            CONV_OCT:  base = BASE_8;
            CONV_HEXL: base = BASE_16;
            CONV_HEXU: base = BASE_16;
            default:   base = BASE_10;
        endcase
    end

    assign full = (r_nd == ND_W'(DIGIT_BUFFER));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_conversion > CONV_HEXU) ? ST_PLAN : ST_DIG_CHECK;
                end
            end
            ST_DIG_CHECK: begin
                n_state = (div_stat.zero || full) ? ST_PLAN : ST_DIG_WAIT;
            end
            ST_DIG_WAIT: begin
                if (div_stat.done) begin
                    n_state = ST_DIG_CHECK;
                end
            end
            ST_PLAN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs; hold the input off while reset is asserted
    always_comb begin
        o_stall   = 1'b1;
        div_start = 1'b0;
        dig_we    = 1'b0;
        plan      = 1'b0;
        case (r_state)
            ST_IDLE:      o_stall   = !i_rst_n;
            ST_DIG_CHECK: div_start = !div_stat.zero && !full;
            ST_DIG_WAIT:  dig_we    = div_stat.done;
            ST_PLAN:      plan      = 1'b1;
            default:      o_stall   = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nd    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_nd <= '0;
            end else if (dig_we) begin
                r_nd <= r_nd + ND_W'(1);
            end
        end
    end

    // hold the spec for the whole item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_spec.conversion      <= i_conversion;
            r_spec.left_justify    <= i_left_justify;
            r_spec.plus_sign       <= i_plus_sign;
            r_spec.space_sign      <= i_space_sign;
            r_spec.zero_pad        <= i_zero_pad;
            r_spec.alternate_form  <= i_alternate_form;
            r_spec.field_width     <= i_field_width;
            r_spec.precision_given <= i_precision_given;
            r_spec.precision       <= i_precision;
            r_spec.negative        <= negative;
        end
    end

    assign div_ctl.load  = accept;
    assign div_ctl.start = div_start;
    assign div_ctl.base  = base;
    assign div_ctl.value = load_value;

    itoa_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_stat  (div_stat)
    );

    itoa_emit #(
        .DIGIT_BUFFER (DIGIT_BUFFER),
        .MAX_OUTPUT   (MAX_OUTPUT)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plan      (plan),
        .i_spec      (r_spec),
        .i_nd        (r_nd),
        .i_dig_we    (dig_we),
        .i_dig_addr  (r_nd[AW-1:0]),
        .i_dig_data  (div_stat.digit),
        .o_busy      (emit_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= ND_W'(DIGIT_BUFFER))
        else $error("digit count past buffer depth");

    a_accept_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !emit_busy)
        else $error("item taken while characters still being generated");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIG_WAIT))
        else $error("divide result outside digit wait");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_res) |-> o_last)
        else $error("empty result not marked last");

endmodule

`default_nettype wire
